// ===== sv/direct_mapped_snoop_cache_controller_defines.svh =====
// assertion macros for the snoop cache controller
`ifndef DIRECT_MAPPED_SNOOP_CACHE_CONTROLLER_DEFINES_SVH
`define DIRECT_MAPPED_SNOOP_CACHE_CONTROLLER_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication, idle during reset
`define DMSC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, idle during reset
`define DMSC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DMSC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define DMSC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== sv/dmsc_pkg.sv =====
package dmsc_pkg;

  localparam int DATA_W     = 32;
  localparam int CFG_REG_W  = 4;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_REG_W-1:0] OFFSET_RESET = 4'd4;
  localparam logic [CFG_REG_W-1:0] INDEX_RESET  = 4'd10;

  // register select, taken from paddr bit 2
  localparam logic CFG_SEL_OFFSET = 1'b0;
  localparam logic CFG_SEL_INDEX  = 1'b1;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_SNOOP = 2'd2,
    OP_INVAL = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_INVALID   = 2'd0,
    ST_SHARED    = 2'd1,
    ST_EXCLUSIVE = 2'd2,
    ST_MODIFIED  = 2'd3
  } mesi_t;

  typedef struct packed {
    logic              hit;
    logic              read_miss_req;
    logic              write_miss_req;
    logic              invalidate_req;
    logic [DATA_W-1:0] request_addr;
    logic              write_back_req;
    logic [DATA_W-1:0] write_back_addr;
  } rsp_t;

endpackage

// ===== sv/dmsc_req_if.sv =====
interface dmsc_req_if import dmsc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        op;
  logic [DATA_W-1:0] addr;

  modport source (output valid, output op, output addr, input ready);
  modport sink   (input valid, input op, input addr, output ready);
endinterface

// ===== sv/dmsc_rsp_if.sv =====
interface dmsc_rsp_if import dmsc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              hit;
  logic              read_miss_req;
  logic              write_miss_req;
  logic              invalidate_req;
  logic [DATA_W-1:0] request_addr;
  logic              write_back_req;
  logic [DATA_W-1:0] write_back_addr;

  modport source (
    output valid, output hit, output read_miss_req, output write_miss_req,
    output invalidate_req, output request_addr, output write_back_req,
    output write_back_addr, input ready
  );
  modport sink (
    input valid, input hit, input read_miss_req, input write_miss_req,
    input invalidate_req, input request_addr, input write_back_req,
    input write_back_addr, output ready
  );
endinterface

// ===== sv/dmsc_addr_split.sv =====
module dmsc_addr_split import dmsc_pkg::*; #(
  parameter int AW      = 32,
  parameter int IDXW    = 10,
  parameter int IDX_CAP = 10
) (
  input  logic [DATA_W-1:0]    addr,
  input  logic [CFG_REG_W-1:0] offset_bits,
  input  logic [CFG_REG_W-1:0] index_bits,
  output logic [DATA_W-1:0]    addr_m,
  output logic [CFG_REG_W-1:0] idx_w,
  output logic [IDXW-1:0]      idx,
  output logic [AW-1:0]        tag
);

  localparam logic [DATA_W-1:0] AMASK = DATA_W'((64'h1 << AW) - 64'h1);
  localparam int CAPC = (IDX_CAP > 15) ? 15 : IDX_CAP;

  logic [DATA_W-1:0] ti;
  logic [DATA_W-1:0] idx_full;
  logic [DATA_W-1:0] tag_full;

  always_comb begin
    addr_m   = addr & AMASK;
    // index width saturates at what the line store can hold
    idx_w    = (index_bits < CFG_REG_W'(CAPC)) ? index_bits : CFG_REG_W'(CAPC);
    ti       = addr_m >> offset_bits;
    idx_full = ti & ~({DATA_W{1'b1}} << idx_w);
    tag_full = ti >> idx_w;
    idx      = idx_full[IDXW-1:0];
    tag      = tag_full[AW-1:0];
  end

endmodule

// ===== sv/dmsc_line_store.sv =====
module dmsc_line_store import dmsc_pkg::*; #(
  parameter int DEPTH = 1024,
  parameter int IDXW  = 10,
  parameter int WW    = 34
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            rd_en,
  input  logic [IDXW-1:0] rd_idx,
  output logic [WW-1:0]   rd_data,
  input  logic            wr_en,
  input  logic [IDXW-1:0] wr_idx,
  input  logic [WW-1:0]   wr_data,
  output logic            clearing
);

  localparam logic [IDXW-1:0] LAST = IDXW'(DEPTH - 1);

  logic [WW-1:0]   mem [DEPTH];
  logic [WW-1:0]   rd_data_r;
  logic            clr_r, clr_nxt;
  logic [IDXW-1:0] cnt_r, cnt_nxt;
  logic            w_en;
  logic [IDXW-1:0] w_idx;
  logic [WW-1:0]   w_data;

  // sweep every line to invalid after reset
  always_comb begin
    clr_nxt = clr_r;
    cnt_nxt = cnt_r;
    if (clr_r) begin
      if (cnt_r == LAST) begin
        clr_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r + IDXW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= 1'b1;
      cnt_r <= '0;
    end else begin
      clr_r <= clr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign w_en   = clr_r | wr_en;
  assign w_idx  = clr_r ? cnt_r : wr_idx;
  assign w_data = clr_r ? '0 : wr_data;

  // write-first on a same-line collision
  always_ff @(posedge clk) begin
    if (w_en) begin
      mem[w_idx] <= w_data;
    end
    if (rd_en) begin
      rd_data_r <= (wr_en && (wr_idx == rd_idx)) ? wr_data : mem[rd_idx];
    end
  end

  assign rd_data  = rd_data_r;
  assign clearing = clr_r;

endmodule

// ===== sv/dmsc_mesi_update.sv =====
module dmsc_mesi_update import dmsc_pkg::*; #(
  parameter int AW   = 32,
  parameter int IDXW = 10
) (
  input  op_t                  op,
  input  logic [DATA_W-1:0]    addr_m,
  input  logic [AW-1:0]        tag,
  input  logic [IDXW-1:0]      idx,
  input  logic [CFG_REG_W-1:0] idx_w,
  input  logic [CFG_REG_W-1:0] offset_bits,
  input  logic [AW+1:0]        line_in,
  output logic [AW+1:0]        line_out,
  output rsp_t                 rsp
);

  localparam logic [DATA_W-1:0] AMASK = DATA_W'((64'h1 << AW) - 64'h1);

  logic [AW-1:0]     old_tag;
  mesi_t             st;
  logic              match;
  logic [AW-1:0]     new_tag;
  mesi_t             new_st;
  logic [DATA_W-1:0] victim;
  logic [DATA_W-1:0] wba;
  logic              hit, rm, wm, inv, wb;

  always_comb begin
    old_tag = line_in[AW+1:2];
    st      = mesi_t'(line_in[1:0]);
    match   = (st != ST_INVALID) && (old_tag == tag);
    victim  = (((DATA_W'(old_tag) << idx_w) | DATA_W'(idx)) << offset_bits) & AMASK;
    new_tag = old_tag;
    new_st  = st;
    hit     = 1'b0;
    rm      = 1'b0;
    wm      = 1'b0;
    inv     = 1'b0;
    wb      = 1'b0;
    wba     = '0;
    unique case (op)
      OP_READ: begin
        if (match) begin
          hit = 1'b1;
        end else begin
          if (st == ST_MODIFIED) begin
            wb  = 1'b1;
            wba = victim;
          end
          rm      = 1'b1;
          new_tag = tag;
          new_st  = ST_SHARED;
        end
      end
      OP_WRITE: begin
        if (match) begin
          hit = 1'b1;
          inv = (st == ST_SHARED);
        end else begin
          if (st == ST_MODIFIED) begin
            wb  = 1'b1;
            wba = victim;
          end
          wm      = 1'b1;
          inv     = 1'b1;
          new_tag = tag;
        end
        new_st = ST_MODIFIED;
      end
      OP_SNOOP: begin
        // a shared copy stays put and reports no hit
        if (match && (st == ST_MODIFIED || st == ST_EXCLUSIVE)) begin
          hit    = 1'b1;
          new_st = ST_SHARED;
          if (st == ST_MODIFIED) begin
            wb  = 1'b1;
            wba = addr_m;
          end
        end
      end
      OP_INVAL: begin
        if (match) begin
          hit    = 1'b1;
          new_st = ST_INVALID;
          if (st == ST_MODIFIED) begin
            wb  = 1'b1;
            wba = addr_m;
          end
        end
      end
      default: begin
      end
    endcase
    line_out            = {new_tag, new_st};
    rsp.hit             = hit;
    rsp.read_miss_req   = rm;
    rsp.write_miss_req  = wm;
    rsp.invalidate_req  = inv;
    rsp.request_addr    = (rm || wm || inv) ? addr_m : '0;
    rsp.write_back_req  = wb;
    rsp.write_back_addr = wba;
  end

endmodule

// ===== sv/direct_mapped_snoop_cache_controller.sv =====
// path: stage 1 beside the registered store read, then the result register
// throughput: one access or snoop per cycle unless the result side stalls, set
//   by the single line store read and write port; back-to-back beats to one
//   line are forwarded at the store
// reset: rst_n synchronous; config returns to offset 4 / index 10, then a
//   clearing pass marks every line invalid; no beat is accepted until it ends,
//   config writes are taken throughout
module direct_mapped_snoop_cache_controller import dmsc_pkg::*; #(
  parameter int ADDR_BITS = 32,
  parameter int MAX_LINES = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  dmsc_req_if.sink              in_ch,
  dmsc_rsp_if.source            out_ch,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

`include "direct_mapped_snoop_cache_controller_defines.svh"

  // address bits that survive the mask; the port stays 32 bits
  localparam int AW      = (ADDR_BITS < DATA_W) ? ADDR_BITS : DATA_W;
  // widest index the store can hold: largest k with 2^k <= MAX_LINES
  localparam int IDX_CAP = $clog2(MAX_LINES + 1) - 1;
  localparam int IDXW    = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam int WW      = AW + 2;

  // ---------------------------------------------------------------------
  // configuration registers, APB write in the access phase
  // ---------------------------------------------------------------------
  logic [CFG_REG_W-1:0] offset_r, offset_nxt;
  logic [CFG_REG_W-1:0] index_r, index_nxt;
  logic                 cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    offset_nxt = offset_r;
    index_nxt  = index_r;
    if (cfg_wr) begin
      unique case (cfg_paddr[2])
        CFG_SEL_OFFSET: offset_nxt = cfg_pwdata[CFG_REG_W-1:0];
        CFG_SEL_INDEX:  index_nxt  = cfg_pwdata[CFG_REG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= OFFSET_RESET;
      index_r  <= INDEX_RESET;
    end else begin
      offset_r <= offset_nxt;
      index_r  <= index_nxt;
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == CFG_SEL_INDEX) ? CFG_DATA_W'(index_r)
                                                      : CFG_DATA_W'(offset_r);

  // ---------------------------------------------------------------------
  // input side: split the address and start the line read
  // ---------------------------------------------------------------------
  logic [DATA_W-1:0]    in_addr_m;
  logic [CFG_REG_W-1:0] idx_w;
  logic [IDXW-1:0]      in_idx;
  logic [AW-1:0]        in_tag;

  dmsc_addr_split #(
    .AW      (AW),
    .IDXW    (IDXW),
    .IDX_CAP (IDX_CAP)
  ) u_split (
    .addr        (in_ch.addr),
    .offset_bits (offset_r),
    .index_bits  (index_r),
    .addr_m      (in_addr_m),
    .idx_w       (idx_w),
    .idx         (in_idx),
    .tag         (in_tag)
  );

  // handshake control
  logic s1_valid_r, s1_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic s1_adv;
  logic in_acc;
  logic clearing;

  // stage 1 advances whenever the result register is free or being drained
  assign s1_adv     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !clearing && (!s1_valid_r || s1_adv);
  assign in_acc     = in_ch.valid && in_ch.ready;

  always_comb begin
    s1_valid_nxt  = in_acc || (s1_valid_r && !s1_adv);
    out_valid_nxt = s1_adv || (out_valid_r && !out_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // stage 1 payload, lines up with the registered store read
  op_t               s1_op_r;
  logic [DATA_W-1:0] s1_addr_r;
  logic [AW-1:0]     s1_tag_r;
  logic [IDXW-1:0]   s1_idx_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r   <= op_t'(in_ch.op);
      s1_addr_r <= in_addr_m;
      s1_tag_r  <= in_tag;
      s1_idx_r  <= in_idx;
    end
  end

  // ---------------------------------------------------------------------
  // line store: tag and MESI state per line, one read and one write a cycle
  // ---------------------------------------------------------------------
  logic [WW-1:0] line_rd;
  logic [WW-1:0] line_wr;

  dmsc_line_store #(
    .DEPTH (MAX_LINES),
    .IDXW  (IDXW),
    .WW    (WW)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_acc),
    .rd_idx   (in_idx),
    .rd_data  (line_rd),
    .wr_en    (s1_adv),
    .wr_idx   (s1_idx_r),
    .wr_data  (line_wr),
    .clearing (clearing)
  );

  // ---------------------------------------------------------------------
  // lookup, MESI transition and bus requests; write back as stage 1 retires
  // ---------------------------------------------------------------------
  rsp_t s1_rsp;
  rsp_t out_rsp_r;

  dmsc_mesi_update #(
    .AW   (AW),
    .IDXW (IDXW)
  ) u_update (
    .op          (s1_op_r),
    .addr_m      (s1_addr_r),
    .tag         (s1_tag_r),
    .idx         (s1_idx_r),
    .idx_w       (idx_w),
    .offset_bits (offset_r),
    .line_in     (line_rd),
    .line_out    (line_wr),
    .rsp         (s1_rsp)
  );

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_rsp_r <= s1_rsp;
    end
  end

  // result beat
  assign out_ch.valid           = out_valid_r;
  assign out_ch.hit             = out_rsp_r.hit;
  assign out_ch.read_miss_req   = out_rsp_r.read_miss_req;
  assign out_ch.write_miss_req  = out_rsp_r.write_miss_req;
  assign out_ch.invalidate_req  = out_rsp_r.invalidate_req;
  assign out_ch.request_addr    = out_rsp_r.request_addr;
  assign out_ch.write_back_req  = out_rsp_r.write_back_req;
  assign out_ch.write_back_addr = out_rsp_r.write_back_addr;

  // ---------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------
  // a hit never raises a miss request
  `DMSC_ASSERT_IMP(a_hit_no_miss, clk, rst_n, out_valid_r && out_rsp_r.hit, !out_rsp_r.read_miss_req && !out_rsp_r.write_miss_req, "hit with miss request")
  // write-back address is zero unless a write-back is raised
  `DMSC_ASSERT_IMP(a_wb_addr_zero, clk, rst_n, out_valid_r && !out_rsp_r.write_back_req, out_rsp_r.write_back_addr == '0, "stray write-back address")
  // a stalled stage 1 keeps its beat and its line
  `DMSC_ASSERT_NXT(a_s1_hold, clk, rst_n, s1_valid_r && !s1_adv, s1_valid_r && $stable(s1_idx_r) && $stable(line_rd), "stage 1 lost its beat")
  // nothing enters while the clearing pass runs
  `DMSC_ASSERT_IMP(a_no_work_clearing, clk, rst_n, clearing, !s1_valid_r && !out_valid_r, "beat in flight during clearing pass")

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import dmsc_pkg::*;

  localparam int CLK_PERIOD     = 8;
  localparam int LINES          = 1024;
  localparam int IDX_CAP        = $clog2(LINES);   // widest index the store can hold
  localparam int TIMEOUT_CYCLES = 200000;
  localparam int LONG_HOLD      = 80;
  localparam int PHASES         = 8;
  localparam int PHASE_BEATS    = 85;
  localparam int HOLD_PHASE     = 3;
  localparam int SHOW_LIMIT     = 10;

  // register map: one 32-bit slot per register, select on paddr bit 2
  localparam logic [CFG_ADDR_W-1:0] REG_OFFSET_ADDR = {CFG_SEL_OFFSET, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] REG_INDEX_ADDR  = {CFG_SEL_INDEX, 2'b00};

  typedef struct packed {
    op_t         op;
    logic [31:0] addr;
  } access_t;

  typedef struct {
    op_t         op;
    logic [31:0] addr;
    rsp_t        rsp;
  } lookup_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  dmsc_req_if access_if ();
  dmsc_rsp_if result_if ();

  direct_mapped_snoop_cache_controller DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (access_if),
    .out_ch      (result_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // shadow of the tag and coherence store plus the address split in use
  logic [31:0] line_tag [LINES];
  mesi_t       line_state [LINES];
  logic [3:0]  cfg_offset = OFFSET_RESET;
  logic [3:0]  cfg_index = INDEX_RESET;

  access_t       access_q[$];      // beats waiting to be offered
  lookup_t       predicted_q[$];   // responses owed by the block, oldest first
  logic [31:0]   recent_addr[$];   // addresses reused to provoke hits and conflicts

  // knobs set by the sequence at the falling edge, read by the edge processes
  bit src_idle_en = 1'b1;
  bit sink_idle_en = 1'b1;
  bit hold_request = 1'b0;

  int src_gap = 0;
  int sink_stall = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int fail_count = 0;
  rsp_t seen;

  // index width after saturation at the store depth
  function automatic int unsigned index_in_use();
    return (cfg_index > IDX_CAP) ? IDX_CAP : cfg_index;
  endfunction

  // one lookup and state update, returns the response it owes
  function automatic rsp_t cache_access(op_t op, logic [31:0] a);
    int unsigned ib;
    logic [63:0] shifted;
    logic [63:0] idx_w;
    logic [63:0] tag_w;
    logic [63:0] victim;
    logic [9:0]  line;
    logic [31:0] tag;
    mesi_t       st;
    logic        match;
    rsp_t        r;
    ib = index_in_use();
    shifted = {32'd0, a} >> cfg_offset;
    idx_w = shifted & ((64'd1 << ib) - 64'd1);
    tag_w = shifted >> ib;
    line = idx_w[9:0];
    tag = tag_w[31:0];
    st = line_state[line];
    match = (st != ST_INVALID) && (line_tag[line] == tag);
    // victim address: stored tag over the index, zero byte offset
    victim = (({32'd0, line_tag[line]} << ib) | idx_w) << cfg_offset;
    r = '0;
    case (op)
      OP_READ: begin
        if (match) begin
          r.hit = 1'b1;
        end else begin
          if (st == ST_MODIFIED) begin
            r.write_back_req = 1'b1;
            r.write_back_addr = victim[31:0];
          end
          r.read_miss_req = 1'b1;
          line_tag[line] = tag;
          line_state[line] = ST_SHARED;   // fill is always shared
        end
      end
      OP_WRITE: begin
        if (match) begin
          r.hit = 1'b1;
          r.invalidate_req = (st != ST_EXCLUSIVE) && (st != ST_MODIFIED);
        end else begin
          if (st == ST_MODIFIED) begin
            r.write_back_req = 1'b1;
            r.write_back_addr = victim[31:0];
          end
          r.write_miss_req = 1'b1;
          r.invalidate_req = 1'b1;
          line_tag[line] = tag;
        end
        line_state[line] = ST_MODIFIED;
      end
      OP_SNOOP: begin
        // a shared line answers no hit and stays as it is
        if (match && (st == ST_MODIFIED || st == ST_EXCLUSIVE)) begin
          r.hit = 1'b1;
          if (st == ST_MODIFIED) begin
            r.write_back_req = 1'b1;
            r.write_back_addr = a;
          end
          line_state[line] = ST_SHARED;
        end
      end
      default: begin
        if (match) begin
          r.hit = 1'b1;
          if (st == ST_MODIFIED) begin
            r.write_back_req = 1'b1;
            r.write_back_addr = a;
          end
          line_state[line] = ST_INVALID;
        end
      end
    endcase
    if (r.read_miss_req || r.write_miss_req || r.invalidate_req)
      r.request_addr = a;
    return r;
  endfunction

  function automatic string show_rsp(rsp_t r);
    return $sformatf("hit=%0b rm=%0b wm=%0b inv=%0b req_addr=%h wb=%0b wb_addr=%h",
                     r.hit, r.read_miss_req, r.write_miss_req, r.invalidate_req,
                     r.request_addr, r.write_back_req, r.write_back_addr);
  endfunction

  task automatic check_result(input rsp_t got);
    lookup_t want;
    if (predicted_q.size() == 0) begin
      fail_count++;
      if (fail_count <= SHOW_LIMIT)
        $display("unexpected result beat: %s", show_rsp(got));
    end else begin
      want = predicted_q.pop_front();
      if (got.hit !== want.rsp.hit || got.read_miss_req !== want.rsp.read_miss_req ||
          got.write_miss_req !== want.rsp.write_miss_req ||
          got.invalidate_req !== want.rsp.invalidate_req ||
          got.request_addr !== want.rsp.request_addr ||
          got.write_back_req !== want.rsp.write_back_req ||
          got.write_back_addr !== want.rsp.write_back_addr) begin
        fail_count++;
        if (fail_count <= SHOW_LIMIT) begin
          $display("mismatch op=%s addr=%h split=%0d/%0d", want.op.name(), want.addr,
                   cfg_offset, cfg_index);
          $display("  expected %s", show_rsp(want.rsp));
          $display("  actual   %s", show_rsp(got));
        end
      end
    end
  endtask

  // driver: offers queued beats, holds a beat until it is taken, idles in bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      access_if.valid <= 1'b0;
      src_gap = 0;
    end else if (!access_if.valid || access_if.ready) begin
      if (src_gap == 0 && src_idle_en && $urandom_range(0, 9) == 0)
        src_gap = $urandom_range(1, 5);
      if (src_gap > 0) begin
        src_gap--;
        access_if.valid <= 1'b0;
      end else if (access_q.size() != 0) begin
        access_if.valid <= 1'b1;
        access_if.op <= access_q[0].op;
        access_if.addr <= access_q[0].addr;
        void'(access_q.pop_front());
      end else begin
        access_if.valid <= 1'b0;
      end
    end
  end

  // result side ready: short random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      result_if.ready <= 1'b0;
      sink_stall = 0;
      hold_left = 0;
    end else begin
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (sink_stall == 0 && sink_idle_en && $urandom_range(0, 7) == 0)
        sink_stall = $urandom_range(1, 5);
      if (hold_left > 0) begin
        hold_left--;
        result_if.ready <= 1'b0;
      end else if (sink_stall > 0) begin
        sink_stall--;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= 1'b1;
      end
    end
  end

  // monitor: predict on every accepted access beat, check every result beat
  always @(posedge clk) begin
    if (rst_n) begin
      if (access_if.valid && access_if.ready)
        predicted_q.push_back('{op: op_t'(access_if.op), addr: access_if.addr,
                                rsp: cache_access(op_t'(access_if.op), access_if.addr)});
      if (result_if.valid && result_if.ready) begin
        seen.hit = result_if.hit;
        seen.read_miss_req = result_if.read_miss_req;
        seen.write_miss_req = result_if.write_miss_req;
        seen.invalidate_req = result_if.invalidate_req;
        seen.request_addr = result_if.request_addr;
        seen.write_back_req = result_if.write_back_req;
        seen.write_back_addr = result_if.write_back_addr;
        check_result(seen);
      end
    end
  end

  // apb write: setup, access, done at the edge where pready is seen high
  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] reg_addr, input logic [3:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= reg_addr;
    cfg_pwdata <= ($urandom & 32'hFFFF_FFF0) | {28'd0, value};   // upper bits are junk
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  // new address split; lines stay valid and are looked up under it
  task automatic set_split(input logic [3:0] ob, input logic [3:0] ib);
    cfg_write(REG_OFFSET_ADDR, ob);
    cfg_offset = ob;
    cfg_write(REG_INDEX_ADDR, ib);
    cfg_index = ib;
    @(negedge clk);
  endtask

  function automatic void push_access(op_t op, logic [31:0] a);
    access_q.push_back('{op: op, addr: a});
  endfunction

  // mostly reused lines: same line at another byte, or same index with another tag
  function automatic logic [31:0] pick_addr();
    logic [31:0] a;
    int unsigned kind;
    int unsigned sh;
    kind = $urandom_range(0, 99);
    sh = cfg_offset + index_in_use();
    if (recent_addr.size() == 0 || kind < 30) begin
      a = $urandom;
    end else begin
      a = recent_addr[$urandom_range(0, recent_addr.size() - 1)];
      if (kind < 70)
        a = a ^ ($urandom & ((32'd1 << cfg_offset) - 32'd1));
      else if (sh < 32)
        a = a ^ (32'($urandom_range(1, 7)) << sh);
      else
        a = $urandom;
    end
    recent_addr.push_back(a);
    if (recent_addr.size() > 16)
      void'(recent_addr.pop_front());
    return a;
  endfunction

  function automatic void queue_random(int beats);
    int unsigned pick;
    op_t op;
    for (int i = 0; i < beats; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 3)
        op = OP_READ;
      else if (pick < 6)
        op = OP_WRITE;
      else if (pick < 8)
        op = OP_SNOOP;
      else
        op = OP_INVAL;
      push_access(op, pick_addr());
    end
  endfunction

  // walk through coherence transitions under the reset split (offset 4, index 10)
  function automatic void queue_directed();
    push_access(OP_READ,  32'h0001_2340);   // cold miss, fills shared
    push_access(OP_READ,  32'h0001_2348);   // hit on another byte of the block
    push_access(OP_WRITE, 32'h0001_2340);   // write hit on shared, upgrade broadcast
    push_access(OP_WRITE, 32'h0001_2348);   // write hit on modified, quiet
    push_access(OP_SNOOP, 32'h0001_2344);   // snoop on modified, write back given address
    push_access(OP_SNOOP, 32'h0001_2340);   // snoop on shared, no hit
    push_access(OP_WRITE, 32'h0005_2340);   // conflict over shared victim, no write back
    push_access(OP_READ,  32'h0001_234C);   // conflict over modified victim
    push_access(OP_INVAL, 32'h0001_2348);   // invalidate shared line
    push_access(OP_INVAL, 32'h0001_2340);   // invalidate with nothing there
    push_access(OP_SNOOP, 32'h0001_2340);   // snoop on invalid line
    push_access(OP_WRITE, 32'hFFFF_FFFF);   // all ones, top line
    push_access(OP_INVAL, 32'hFFFF_FFF0);   // invalidate modified, write back
    push_access(OP_WRITE, 32'h0000_0000);   // all zeros, line zero
    push_access(OP_WRITE, 32'h0000_000F);
    push_access(OP_READ,  32'h0000_4000);   // victim rebuilt as address zero
    push_access(OP_READ,  32'hFFFF_FFFF);
    push_access(OP_WRITE, 32'h8000_3FF0);   // replace shared top line
    push_access(OP_SNOOP, 32'h8000_3FF5);
    push_access(OP_INVAL, 32'h8000_3FF5);
  endfunction

  task automatic wait_drained();
    do @(negedge clk);
    while (access_q.size() != 0 || access_if.valid || predicted_q.size() != 0);
  endtask

  initial begin
    logic [3:0] split_ob [PHASES];
    logic [3:0] split_ib [PHASES];
    // extremes first, then wide offset, saturated index, zero offset, zero index, a random split, and back to reset
    split_ob = '{4'd0, 4'd15, 4'd12, 4'd13, 4'd0, 4'd12, 4'd4, 4'd4};
    split_ib = '{4'd0, 4'd15, 4'd10, 4'd11, 4'd10, 4'd0, 4'd10, 4'd10};
    split_ob[6] = 4'($urandom_range(0, 15));
    split_ib[6] = 4'($urandom_range(0, 15));
    for (int i = 0; i < LINES; i++) begin
      line_tag[i] = '0;
      line_state[i] = ST_INVALID;
    end
    access_if.valid = 1'b0;
    access_if.op = OP_READ;
    access_if.addr = '0;
    result_if.ready = 1'b0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part under the reset split; the block clears its store first
    queue_directed();
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      // no source idling while the result side holds off, none at all at the end
      src_idle_en = (p != HOLD_PHASE) && (p != PHASES - 1);
      sink_idle_en = (p != PHASES - 1);
      if (p == HOLD_PHASE)
        hold_request = 1'b1;
      set_split(split_ob[p], split_ib[p]);
      queue_random(PHASE_BEATS);
      wait_drained();
    end

    // allow slack past the result path before the final count
    repeat (8) @(posedge clk);
    fail_count += predicted_q.size();
    if (fail_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // watchdog covering the clearing pass and the slowest stall pattern many times over
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/dmsc_pkg.sv
sv/dmsc_req_if.sv
sv/dmsc_rsp_if.sv
sv/dmsc_addr_split.sv
sv/dmsc_line_store.sv
sv/dmsc_mesi_update.sv
sv/direct_mapped_snoop_cache_controller.sv
test/tb.sv
